// File: rtl/pjm_pkg.sv
// Package: shared types and constants for the period jitter monitor table.
package pjm_pkg;

  localparam logic [1:0] ModeInit   = 2'd0;
  localparam logic [1:0] ModeCheck  = 2'd1;
  localparam logic [1:0] ModeReport = 2'd2;
  localparam logic [1:0] ModeNone   = 2'd3;

  localparam int unsigned MinExpected = 200;
  localparam int unsigned RangeDiv    = 20;
  localparam int unsigned PercentDiv  = 100;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  index;
    logic [31:0] timestamp;
    logic [31:0] expected_period;
    logic [4:0]  tolerance_percent;
  } pjm_in_t;

  typedef struct packed {
    logic        accepted;
    logic        in_window;
    logic [31:0] call_count;
    logic [31:0] violation_count;
    logic [31:0] pass_count;
    logic [31:0] min_period;
    logic [31:0] max_period;
    logic [31:0] mean_period;
  } pjm_out_t;

endpackage

// File: rtl/pjm_front.sv
// Front end: accepts items, classifies them and pushes commands into a queue.
module pjm_front #(
  parameter int unsigned Entries = 16,
  parameter int unsigned QDepth  = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pjm_pkg::pjm_in_t item_i,
  output logic            busy_o,
  output logic            q_valid_o,
  output pjm_pkg::pjm_in_t q_item_o,
  output logic            q_skip_o,
  input  logic            q_pop_i
);
  import pjm_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  pjm_in_t          mem_q [QDepth];
  logic [QDepth-1:0] skip_q;
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push, skip;

  assign busy_o = (cnt_q == (PtrW+1)'(QDepth));
  assign push   = start_i && !busy_o;
  assign skip   = (item_i.mode == ModeNone) || ({28'd0, item_i.index} >= 32'(Entries));

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];
  assign q_skip_o  = skip_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      skip_q <= '0;
    end else begin
      if (push) begin
        skip_q[wr_q] <= skip;
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

endmodule

// File: rtl/pjm_div.sv
// Iterative restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
module pjm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [6:0]  cnt_q;
  logic        run_q;
  logic        done_q;
  logic [32:0] shifted;
  logic        ge;

  assign shifted = {rem_q[31:0], quo_q[63]};
  assign ge      = shifted >= {1'b0, den_q};
  assign quo_o   = quo_q;
  assign done_o  = done_q;

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? shifted - {1'b0, den_q} : shifted;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/pjm_back.sv
// Back end: per-entry statistics memory and the init, check and report sequencer.
module pjm_back #(
  parameter int unsigned Entries  = 16,
  parameter int unsigned TimeBits = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  pjm_pkg::pjm_in_t q_item_i,
  input  logic             q_skip_i,
  output logic             q_pop_o,
  output logic             valid_o,
  output pjm_pkg::pjm_out_t result_o
);
  import pjm_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [TimeBits-1:0] TMax = {TimeBits{1'b1}};
  localparam logic [TimeBits-1:0] ExpMax = TimeBits'(TMax / RangeDiv);
  // ceil(2^36/25): exact quotient by 25 for 31-bit operands
  localparam logic [31:0] PctRecip = 32'd2748779070;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StPct  = 3'd5;

  typedef struct packed {
    logic [TimeBits-1:0] last;
    logic [31:0]         calls;
    logic [31:0]         viol;
    logic [31:0]         pass;
    logic [TimeBits-1:0] mn;
    logic [TimeBits-1:0] mx;
    logic [63:0]         sum;
  } stat_t;

  typedef struct packed {
    logic [TimeBits-1:0] lo;
    logic [TimeBits-1:0] hi;
  } win_t;

  stat_t            stat_mem [Entries];
  win_t             win_mem  [Entries];
  logic [Entries-1:0] valid_q;
  logic [Entries-1:0] wvalid_q;

  logic [2:0]       st_q;
  pjm_in_t          it_q;
  stat_t            rs_q, ws;
  win_t             rw_q, ww;
  logic             rv_q;
  logic             rwv_q;
  logic             we_s, we_w;
  logic [IdxW-1:0]  idx;
  stat_t            cur;
  win_t             cw;
  logic [TimeBits-1:0] diff;
  logic             inw;
  logic [TimeBits+4:0] prod_q;
  logic [30:0]      pq4;
  logic [62:0]      recip_p;
  logic [TimeBits-1:0] var_q;
  logic             div_go, div_done;
  logic [63:0]      quo;
  logic             valid_q_o;
  pjm_out_t         res_q, res_d;
  logic [TimeBits-1:0] expv;

  assign idx  = it_q.index[IdxW-1:0];
  assign expv = it_q.expected_period[TimeBits-1:0];
  assign cur  = rv_q ? rs_q : '0;
  assign cw   = rwv_q ? rw_q : '0;
  assign diff = it_q.timestamp[TimeBits-1:0] - cur.last;
  assign inw  = !((diff < cw.lo) || (diff > cw.hi));

  // percent scaling: divide by 4, then by 25 through the reciprocal
  assign pq4     = 31'(prod_q >> 2);
  assign recip_p = 63'(pq4) * 63'(PctRecip);

  pjm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (cur.sum),
    .den_i  (cur.calls),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i) begin
    rs_q <= stat_mem[idx];
    rw_q <= win_mem[idx];
    if (we_s) begin
      stat_mem[idx] <= ws;
    end
    if (we_w) begin
      win_mem[idx] <= ww;
    end
    prod_q <= expv * it_q.tolerance_percent;
    var_q  <= TimeBits'(recip_p[62:36]);
    res_q  <= res_d;
  end

  function automatic logic [31:0] ext(input logic [TimeBits-1:0] v);
    return 32'(v);
  endfunction

  always_comb begin
    ws      = cur;
    ww      = cw;
    we_s    = 1'b0;
    we_w    = 1'b0;
    div_go  = 1'b0;
    q_pop_o = 1'b0;
    res_d   = res_q;
    if (st_q == StExec) begin
      q_pop_o = 1'b1;
      res_d = '0;
      res_d.accepted = 1'b1;
      if (q_skip_i) begin
        res_d.accepted = (it_q.mode != ModeInit);
      end else begin
        case (it_q.mode)
          ModeInit: begin
            ws = '0;
            ws.mn = TMax;
            we_s = 1'b1;
          end
          ModeCheck: begin
            if (cur.calls != '0) begin
              if (inw) begin
                ws.pass = cur.pass + 32'd1;
              end else begin
                ws.viol = cur.viol + 32'd1;
              end
              if (diff < cur.mn) ws.mn = diff;
              if (diff > cur.mx) ws.mx = diff;
              ws.sum = cur.sum + 64'(diff);
              res_d.in_window = inw;
            end
            ws.last  = it_q.timestamp[TimeBits-1:0];
            ws.calls = cur.calls + 32'd1;
            we_s = 1'b1;
          end
          ModeReport: begin
            div_go = (cur.calls != '0);
          end
          default: ;
        endcase
        res_d.call_count      = ws.calls;
        res_d.violation_count = ws.viol;
        res_d.pass_count      = ws.pass;
        res_d.min_period      = ext(ws.mn);
        res_d.max_period      = ext(ws.mx);
        if (it_q.mode == ModeInit) begin
          res_d.accepted = (expv >= TimeBits'(MinExpected)) && (expv <= ExpMax);
        end
      end
    end
    if (st_q == StDiv && div_done) begin
      res_d.mean_period = (quo[63:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
    end
    if (st_q == StPct) begin
      ww.lo = expv - var_q;
      ww.hi = expv + var_q;
      we_w  = 1'b1;
    end
  end

  assign valid_o  = valid_q_o;
  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i) begin
      it_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      rv_q      <= 1'b0;
      rwv_q     <= 1'b0;
      valid_q   <= '0;
      wvalid_q  <= '0;
      valid_q_o <= 1'b0;
    end else begin
      valid_q_o <= 1'b0;
      case (st_q)
        StIdle: if (q_valid_i) st_q <= StRead;
        StRead: begin
          rv_q  <= valid_q[idx];
          rwv_q <= wvalid_q[idx];
          st_q  <= StExec;
        end
        StExec: begin
          if (we_s) valid_q[idx] <= 1'b1;
          if (!q_skip_i && it_q.mode == ModeReport && cur.calls != '0) begin
            st_q <= StDiv;
          end else if (!q_skip_i && it_q.mode == ModeInit && res_d.accepted) begin
            st_q <= StMul;
            valid_q_o <= 1'b1;
          end else begin
            st_q <= StIdle;
            valid_q_o <= 1'b1;
          end
        end
        StMul: st_q <= StPct;
        StPct: begin
          wvalid_q[idx] <= 1'b1;
          st_q <= StIdle;
        end
        StDiv: begin
          if (div_done) begin
            st_q <= StIdle;
            valid_q_o <= 1'b1;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

// File: rtl/period_jitter_monitor_table.sv
// Top level: period jitter monitor table, front queue plus statistics back end.
// A report waits for a 64-step divider that computes the mean. Sequential: one
// item in the back end at a time; an accepted init goes on to the multiply and
// percent states after its result; a two-deep queue absorbs items meanwhile;
// busy when it is full.
// Reset clears the control state and the entry valid bits, so every entry
// reads as zero until it is first written; no clearing pass is needed.
module period_jitter_monitor_table #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  pjm_pkg::pjm_in_t  item_i,
  output logic              busy,
  output logic              done_o,
  output pjm_pkg::pjm_out_t result_o
);
  import pjm_pkg::*;

  logic    q_valid, q_skip, q_pop;
  pjm_in_t q_item;

  pjm_front #(.Entries(ENTRIES), .QDepth(2)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .item_i    (item_i),
    .busy_o    (busy),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_skip_o  (q_skip),
    .q_pop_i   (q_pop)
  );

  pjm_back #(.Entries(ENTRIES), .TimeBits(TIME_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_skip_i  (q_skip),
    .q_pop_o   (q_pop),
    .valid_o   (done_o),
    .result_o  (result_o)
  );

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !result_o.in_window || result_o.pass_count != '0)
    else $error("in-window result without a pass");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back results");
`endif

endmodule

// File: sim/period_jitter_monitor_table_checker.sv
// Checker: predicts monitor table results from accepted items and compares them.
module period_jitter_monitor_table_checker
  import pjm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  pjm_in_t  item_i,
  input  logic     done_o,
  input  pjm_out_t result_o,
  output int       fail_count,
  output int       pending,
  output int       result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] last_stamp [16];
  logic [31:0] calls      [16];
  logic [31:0] violations [16];
  logic [31:0] passes     [16];
  logic [31:0] min_seen   [16];
  logic [31:0] max_seen   [16];
  logic [63:0] period_sum [16];
  logic [31:0] win_low    [16];
  logic [31:0] win_high   [16];

  pjm_out_t expected_q[$];

  function automatic pjm_out_t monitor_update(pjm_in_t it);
    pjm_out_t r;
    logic [3:0] ix;
    logic [31:0] diff;
    logic [63:0] var_amt, mean;
    r = '0;
    ix = it.index;
    r.accepted = (it.mode != ModeInit);
    if (it.mode == ModeNone) return r;
    case (it.mode)
      ModeInit: begin
        calls[ix] = 0; violations[ix] = 0; passes[ix] = 0;
        min_seen[ix] = '1; max_seen[ix] = 0; period_sum[ix] = 0; last_stamp[ix] = 0;
        if (it.expected_period >= MinExpected &&
            it.expected_period <= 32'hFFFF_FFFF / RangeDiv) begin
          var_amt = (64'(it.expected_period) * it.tolerance_percent) / PercentDiv;
          win_low[ix] = 32'(64'(it.expected_period) - var_amt);
          win_high[ix] = 32'(64'(it.expected_period) + var_amt);
          r.accepted = 1'b1;
        end
      end
      ModeCheck: begin
        if (calls[ix] != 0) begin
          diff = it.timestamp - last_stamp[ix];
          if (diff < win_low[ix] || diff > win_high[ix]) violations[ix]++;
          else begin
            passes[ix]++;
            r.in_window = 1'b1;
          end
          if (diff < min_seen[ix]) min_seen[ix] = diff;
          if (diff > max_seen[ix]) max_seen[ix] = diff;
          period_sum[ix] += 64'(diff);
        end
        last_stamp[ix] = it.timestamp;
        calls[ix]++;
      end
      default: begin
        if (calls[ix] != 0) begin
          mean = period_sum[ix] / calls[ix];
          r.mean_period = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
        end
      end
    endcase
    r.call_count = calls[ix];
    r.violation_count = violations[ix];
    r.pass_count = passes[ix];
    r.min_period = min_seen[ix];
    r.max_period = max_seen[ix];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (fail_count < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pjm_out_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        last_stamp[i] = 0; calls[i] = 0; violations[i] = 0; passes[i] = 0;
        min_seen[i] = 0; max_seen[i] = 0; period_sum[i] = 0;
        win_low[i] = 0; win_high[i] = 0;
      end
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
      pending = 0;
    end else begin
      if (done_o) begin
        result_count++;
        if (expected_q.size() == 0) note_mismatch("unexpected result", 0, 1);
        else begin
          e = expected_q.pop_front();
          if (result_o.accepted != e.accepted)
            note_mismatch("accepted", e.accepted, result_o.accepted);
          if (result_o.in_window != e.in_window)
            note_mismatch("in_window", e.in_window, result_o.in_window);
          if (result_o.call_count != e.call_count)
            note_mismatch("call_count", e.call_count, result_o.call_count);
          if (result_o.violation_count != e.violation_count)
            note_mismatch("violation_count", e.violation_count, result_o.violation_count);
          if (result_o.pass_count != e.pass_count)
            note_mismatch("pass_count", e.pass_count, result_o.pass_count);
          if (result_o.min_period != e.min_period)
            note_mismatch("min_period", e.min_period, result_o.min_period);
          if (result_o.max_period != e.max_period)
            note_mismatch("max_period", e.max_period, result_o.max_period);
          if (result_o.mean_period != e.mean_period)
            note_mismatch("mean_period", e.mean_period, result_o.mean_period);
        end
      end
      if (start && !busy) expected_q.push_back(monitor_update(item_i));
      pending = expected_q.size();
    end
  end
endmodule

// File: sim/period_jitter_monitor_table_tb.sv
// Testbench top: drives monitor table items and reports the verdict.
module period_jitter_monitor_table_tb;
  import pjm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  pjm_in_t  item_i = '0;
  logic     busy, done_o;
  pjm_out_t result_o;
  int       fail_count, pending, result_count;
  int       item_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  period_jitter_monitor_table dut (
    .clk_i, .rst_ni, .start, .item_i, .busy, .done_o, .result_o
  );

  period_jitter_monitor_table_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .fail_count, .pending, .result_count
  );

  logic [31:0] stamp_base [16];

  // present one item and hold it until accepted
  task automatic send_item(logic [1:0] md, logic [3:0] ix, logic [31:0] ts,
                           logic [31:0] ep, logic [4:0] pc);
    start <= 1'b1;
    item_i <= '{mode: md, index: ix, timestamp: ts, expected_period: ep,
                tolerance_percent: pc};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    item_count++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    logic [3:0] ix;
    logic [31:0] ep, jit;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(ModeCheck, 4'd3, 32'd1000, 32'd0, 5'd0);
    send_item(ModeCheck, 4'd3, 32'd1000, 32'd0, 5'd0);
    send_item(ModeReport, 4'd3, 32'd0, 32'd0, 5'd0);
    send_item(ModeReport, 4'd7, '1, '1, '1);
    send_item(ModeNone, 4'd1, '1, '1, '1);
    send_item(ModeInit, 4'd0, 32'd0, 32'd199, 5'd10);
    send_item(ModeInit, 4'd1, 32'd0, 32'd200, 5'd0);
    send_item(ModeInit, 4'd2, 32'd0, 32'hFFFF_FFFF / 20, 5'd20);
    send_item(ModeInit, 4'd4, 32'd0, 32'hFFFF_FFFF / 20 + 1, 5'd5);
    send_item(ModeInit, 4'd15, 32'd0, 32'd1000, 5'd31);
    send_item(ModeInit, 4'd5, '1, '1, '1);
    send_item(ModeCheck, 4'd15, 32'hFFFF_FF00, '1, '1);
    send_item(ModeCheck, 4'd15, 32'h0000_02E8, 32'd0, 5'd0);
    send_item(ModeCheck, 4'd15, 32'h0000_0AE8, 32'd0, 5'd0);
    send_item(ModeCheck, 4'd15, 32'h0000_0AE8, 32'd0, 5'd0);
    send_item(ModeReport, 4'd15, 32'd0, 32'd0, 5'd0);
    send_item(ModeCheck, 4'd2, 32'd0, 32'd0, 5'd0);
    send_item(ModeCheck, 4'd2, '1, 32'd0, 5'd0);
    send_item(ModeReport, 4'd2, 32'd0, 32'd0, 5'd0);
    send_item(ModeInit, 4'd2, 32'd0, 32'd200, 5'd0);
    send_item(ModeReport, 4'd2, 32'd0, 32'd0, 5'd0);
    wait_drain();

    for (int i = 0; i < 16; i++) stamp_base[i] = $urandom;
    while (item_count < 820) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        ix = 4'($urandom);
        case ($urandom_range(0, 19))
          0: send_item(2'($urandom), 4'($urandom), $urandom, $urandom, 5'($urandom));
          1, 2: begin
            ep = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(150, 5000);
            send_item(ModeInit, ix, $urandom, ep, 5'($urandom_range(0, 31)));
          end
          3, 4: send_item(ModeReport, ix, $urandom, $urandom, 5'($urandom));
          default: begin
            jit = $urandom_range(0, 1) ? $urandom_range(800, 1200) : $urandom;
            if ($urandom_range(0, 3) != 0) jit = $urandom_range(150, 5000);
            stamp_base[ix] += jit;
            send_item(ModeCheck, ix, stamp_base[ix], $urandom, 5'($urandom));
          end
        endcase
      end
      if ($urandom_range(0, 40) == 0) wait_drain();
      else if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 10));
    end
    wait_drain();
    repeat (80) @(posedge clk_i);

    $display("Sent %0d items over inits, checks, reports and unused modes on all 16 entries;",
             item_count);
    $display("%0d results compared, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
